[rtl/tms_pkg.sv]
// Package for the tick melody tone sequencer: sizing constants, command codes,
// word types and the control/status structs between controller and datapath.
// No dependencies.
package tms_pkg;

    localparam int NOTES_PER_MELODY = 32;
    localparam int MELODY_COUNT     = 3;
    localparam int GAP_TICKS        = 10;

    localparam int STORE_DEPTH = MELODY_COUNT * NOTES_PER_MELODY;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = $clog2(NOTES_PER_MELODY + 1);

    localparam int TONE_CLOCK  = 1000000;
    localparam int QUO_W       = $clog2(TONE_CLOCK + 1);
    localparam int DIV_STEPS   = QUO_W;
    localparam int DCNT_W      = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  melody_sel;
        logic [4:0]  entry_index;
        logic [15:0] note_freq_hz;
        logic [15:0] note_ticks;
    } req_word_t;

    typedef struct packed {
        logic [15:0] tone_period;
        logic        playing;
    } rsp_word_t;

    typedef struct packed {
        logic [15:0] freq;
        logic [15:0] ticks;
    } note_entry_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // apply the accepted request word
        logic fetch;    // apply the note read from the table
        logic finish;   // take the divider quotient as the period
        logic emit;     // load the response register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_fetch;
        logic freq_zero;
        logic div_done;
    } dp_status_t;

endpackage

[rtl/tick_melody_tone_sequencer_unit.sv]
// Top level of the tick melody tone sequencer.
// Depends on tms_pkg, tms_ctrl, tms_datapath (with tms_ram, tms_div).
//
//  channel | signals                         | word
//  --------+---------------------------------+----------------------------------
//  request | req_valid, req_ready, req_data  | command, melody, index, freq, ticks
//  response| rsp_valid, rsp_ready, rsp_data  | tone_period, playing
//
// One response word per request word, in order. Load, start, stop and ticks that
// fetch nothing pass through accept and emit; a tick reading a zero note adds the read.
// A tick that fetches a note passes through accept, table RAM read, 20 restoring-divider
// steps for 1000000 / freq, quotient take and emit.
// Reset clears playback state only; melody tables are undefined until loaded.
// A held response stalls the emit step; no new request is taken until it is emitted.
module tick_melody_tone_sequencer_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  tms_pkg::req_word_t req_data,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output tms_pkg::rsp_word_t rsp_data
);

    tms_pkg::dp_cmd_t    cmd;
    tms_pkg::dp_status_t status;

    // sequencing of each word
    tms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // playback registers, melody tables, divider and response word
    tms_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req_data),
        .cmd      (cmd),
        .status   (status),
        .rsp_data (rsp_data)
    );

endmodule

[rtl/tms_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 96
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/tms_div.sv]
// Restoring divider, one quotient bit per cycle: TONE_CLOCK / divisor.
// Depends on tms_pkg.
module tms_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [15:0]               divisor,
    output logic                      done,
    output logic [tms_pkg::QUO_W-1:0] quotient
);

    logic [tms_pkg::QUO_W-1:0]  quo_reg, quo_next;
    logic [15:0]                rem_reg, rem_next;
    logic [15:0]                dvs_reg, dvs_next;
    logic [tms_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic                       run_reg, run_next;
    logic [16:0]                trial;
    logic [17:0]                diff;

    assign done     = run_reg && (cnt_reg == '0);
    assign quotient = quo_reg;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[tms_pkg::QUO_W-1]};
        diff     = {1'b0, trial} - {2'b00, dvs_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        if (start)
        begin
            quo_next = tms_pkg::QUO_W'(tms_pkg::TONE_CLOCK);
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = tms_pkg::DCNT_W'(tms_pkg::DIV_STEPS);
            run_next = 1'b1;
        end
        else if (done)
        begin
            run_next = 1'b0;
        end
        else if (run_reg)
        begin
            // borrow means the trial remainder stays
            rem_next = diff[17] ? trial[15:0] : diff[15:0];
            quo_next = {quo_reg[tms_pkg::QUO_W-2:0], ~diff[17]};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            run_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

[rtl/tms_datapath.sv]
// Datapath: playback state, melody table RAM, period divider, response register.
// Depends on tms_pkg, tms_ram, tms_div.
module tms_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  tms_pkg::req_word_t  req_data,
    input  tms_pkg::dp_cmd_t    cmd,
    output tms_pkg::dp_status_t status,
    output tms_pkg::rsp_word_t  rsp_data
);

    logic [tms_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [1:0]                mel_reg, mel_next;
    logic                      busy_reg, busy_next;
    logic                      pend_reg, pend_next;
    logic [3:0]                gap_reg, gap_next;
    logic [15:0]               ticks_reg, ticks_next;
    logic [15:0]               period_reg, period_next;
    tms_pkg::rsp_word_t        rsp_reg;

    logic                       in_range;
    logic                       wr_en, rd_en, div_start;
    logic [tms_pkg::ADDR_W-1:0] wr_addr, rd_addr;
    tms_pkg::note_entry_t       wr_entry, rd_entry;
    logic [tms_pkg::QUO_W-1:0]  quotient;
    logic                       div_done;
    logic [15:0]                dec_ticks;

    assign in_range = (32'(pos_reg) < tms_pkg::NOTES_PER_MELODY)
                   && (32'(mel_reg) < tms_pkg::MELODY_COUNT);
    assign rd_addr  = tms_pkg::ADDR_W'(32'(mel_reg) * tms_pkg::NOTES_PER_MELODY
                                       + 32'(pos_reg));
    assign wr_addr  = tms_pkg::ADDR_W'(32'(req_data.melody_sel) * tms_pkg::NOTES_PER_MELODY
                                       + 32'(req_data.entry_index));
    assign wr_entry = '{freq: req_data.note_freq_hz, ticks: req_data.note_ticks};

    assign status.need_fetch = (req_data.command == tms_pkg::CMD_TICK) && busy_reg
                            && (gap_reg == '0) && pend_reg && in_range;
    assign status.freq_zero  = (rd_entry.freq == '0);
    assign status.div_done   = div_done;

    assign rd_en     = cmd.accept && status.need_fetch;
    assign wr_en     = cmd.accept && (req_data.command == tms_pkg::CMD_LOAD)
                    && (32'(req_data.melody_sel) < tms_pkg::MELODY_COUNT)
                    && (32'(req_data.entry_index) < tms_pkg::NOTES_PER_MELODY);
    assign div_start = cmd.fetch && !status.freq_zero;
    assign dec_ticks = ticks_reg - 16'd1;
    assign rsp_data  = rsp_reg;

    tms_ram #(
        .WIDTH ($bits(tms_pkg::note_entry_t)),
        .DEPTH (tms_pkg::STORE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    tms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (rd_entry.freq),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        pos_next    = pos_reg;
        mel_next    = mel_reg;
        busy_next   = busy_reg;
        pend_next   = pend_reg;
        gap_next    = gap_reg;
        ticks_next  = ticks_reg;
        period_next = period_reg;
        if (cmd.accept)
        begin
            unique case (req_data.command)
                tms_pkg::CMD_TICK:
                begin
                    if (busy_reg)
                    begin
                        if (gap_reg != '0)
                        begin
                            period_next = '0;
                            gap_next    = gap_reg - 1'b1;
                        end
                        else if (pend_reg)
                        begin
                            // in range: table read issued, note applied on fetch
                            if (!in_range)
                            begin
                                busy_next   = 1'b0;
                                pend_next   = 1'b1;
                                gap_next    = '0;
                                ticks_next  = '0;
                                period_next = '0;
                            end
                        end
                        else
                        begin
                            ticks_next = dec_ticks;
                            if (dec_ticks == '0)
                            begin
                                pend_next = 1'b1;
                                gap_next  = 4'(tms_pkg::GAP_TICKS);
                            end
                        end
                    end
                end
                tms_pkg::CMD_LOAD:
                begin
                    // table write only
                end
                tms_pkg::CMD_START:
                begin
                    if (32'(req_data.melody_sel) < tms_pkg::MELODY_COUNT)
                    begin
                        busy_next   = 1'b1;
                        pend_next   = 1'b1;
                        gap_next    = '0;
                        ticks_next  = '0;
                        period_next = '0;
                        mel_next    = req_data.melody_sel;
                        pos_next    = '0;
                    end
                end
                tms_pkg::CMD_STOP:
                begin
                    busy_next   = 1'b0;
                    pend_next   = 1'b1;
                    gap_next    = '0;
                    ticks_next  = '0;
                    period_next = '0;
                end
            endcase
        end
        else if (cmd.fetch)
        begin
            if (status.freq_zero)
            begin
                busy_next   = 1'b0;
                pend_next   = 1'b1;
                gap_next    = '0;
                ticks_next  = '0;
                period_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                // the fetching tick also counts one tick of the note
                if (rd_entry.ticks <= 16'd1)
                begin
                    ticks_next = '0;
                    pend_next  = 1'b1;
                    gap_next   = 4'(tms_pkg::GAP_TICKS);
                end
                else
                begin
                    ticks_next = rd_entry.ticks - 16'd1;
                    pend_next  = 1'b0;
                end
            end
        end
        else if (cmd.finish)
        begin
            period_next = (|quotient[tms_pkg::QUO_W-1:16]) ? 16'hFFFF : quotient[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            mel_reg    <= '0;
            busy_reg   <= 1'b0;
            pend_reg   <= 1'b1;
            gap_reg    <= '0;
            ticks_reg  <= '0;
            period_reg <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            mel_reg    <= mel_next;
            busy_reg   <= busy_next;
            pend_reg   <= pend_next;
            gap_reg    <= gap_next;
            ticks_reg  <= ticks_next;
            period_reg <= period_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_reg <= '{tone_period: period_reg, playing: busy_reg};
        end
    end

    // idle player is always silent and due to fetch
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (period_reg == '0) && pend_reg)
        else $error("idle player not silent");

    a_fetch_moves_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fetch && !status.freq_zero) |=> (pos_reg == $past(pos_reg) + 1'b1))
        else $error("note position not advanced on fetch");

    // a gap only runs while playing, with the next note due
    a_gap_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (gap_reg != '0) |-> busy_reg && pend_reg)
        else $error("gap running outside playback");

endmodule

[rtl/tms_ctrl.sv]
// Controller: sequences accept, table read, divide and response for each word.
// Depends on tms_pkg.
module tms_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  tms_pkg::dp_status_t status,
    output tms_pkg::dp_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       slot_free;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.need_fetch ? S_FETCH : S_EMIT;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = status.freq_zero ? S_EMIT : S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_fetch_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && status.need_fetch) |=> (state_reg == S_FETCH))
        else $error("table read not followed by fetch");

    a_div_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && status.div_done) |=> (state_reg == S_EMIT))
        else $error("divider done ignored");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> rsp_valid_reg && (state_reg == S_IDLE))
        else $error("response not presented after emit");

endmodule
